// ===== design/adq_pkg.sv =====
// Package for the array deque with id search.
// Shared constants, operation and status codes, entry and sequencer state types.
// No dependencies.
package adq_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int OP_W      = 3;
   localparam int ID_W      = 32;
   localparam int PAY_W     = 32;
   localparam int STAT_W    = 2;
   localparam int OCC_W     = 7;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND_ID    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SHIFT,
      ST_WRNEW,
      ST_FIND,
      ST_DONE
   } state_type;

endpackage

// ===== design/adq_ifc.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on adq_pkg for field widths.
interface adq_req_ifc;
   logic                          valid;
   logic                          ready;
   logic [adq_pkg::OP_W-1:0]      op;
   logic signed [adq_pkg::ID_W-1:0] customer_id;
   logic [adq_pkg::PAY_W-1:0]     entry_payload;

   modport source (output valid, output op, output customer_id, output entry_payload,
                   input ready);
   modport sink   (input valid, input op, input customer_id, input entry_payload,
                   output ready);
endinterface

interface adq_rsp_ifc;
   logic                            valid;
   logic                            ready;
   logic [adq_pkg::STAT_W-1:0]      status;
   logic signed [adq_pkg::ID_W-1:0] out_id;
   logic [adq_pkg::PAY_W-1:0]       out_payload;
   logic [adq_pkg::OCC_W-1:0]       occupancy;

   modport source (output valid, output status, output out_id, output out_payload,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_id, input out_payload,
                   input occupancy, output ready);
endinterface

// ===== design/array_deque_with_id_search_top.sv =====
// Array deque with id search: top level.
// A push that needs no shift, a full/empty answer or an unused code goes straight
// to the response register; a pop reads the store first; a front push at slot 0
// moves every entry up (one store read/write per entry moved), then writes the
// new entry; a find reads one entry per compare until a hit or the tail. One
// request at a time: the next is taken the cycle after the response register loads.
// Reset (synchronous): empty queue, indices zero; store contents stay undefined.
//
// Depends on adq_pkg, adq_ifc, adq_mem, adq_ctrl.
module array_deque_with_id_search_top #(
   parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   adq_req_ifc.sink   req_if,
   adq_rsp_ifc.source rsp_if
);

   localparam int AW = $clog2(DEPTH);

   // store port signals between the sequencer and the entry memory
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   adq_pkg::entry_type mem_wdata;
   adq_pkg::entry_type mem_rdata;

   // sequencer: decodes each transaction, walks the store for shifts and
   // searches, and holds the response register so a new request can be taken
   // while the last response still waits
   adq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // entry store: id and payload side by side, registered read
   adq_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

// ===== design/adq_mem.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on adq_pkg for the entry type.
module adq_mem #(
   parameter int DEPTH = adq_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  adq_pkg::entry_type wdata,
   input  logic [AW-1:0]      raddr,
   output adq_pkg::entry_type rdata
);

   adq_pkg::entry_type mem_q [DEPTH];
   adq_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_q[waddr] <= wdata;
      end
      rdata_ff <= mem_q[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/adq_ctrl.sv =====
// Sequencer for the deque: index bookkeeping, shift and search walks over the
// store, result staging and the response register. Depends on adq_pkg, adq_ifc.
module adq_ctrl #(
   parameter int DEPTH = adq_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   adq_req_ifc.sink           req_if,
   adq_rsp_ifc.source         rsp_if,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output adq_pkg::entry_type mem_wdata,
   output logic [AW-1:0]      mem_raddr,
   input  adq_pkg::entry_type mem_rdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   adq_pkg::state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in, rptr_ff, rptr_in;
   logic          empty_ff, empty_in;

   logic [adq_pkg::ID_W-1:0]   key_ff, key_in;
   logic [adq_pkg::PAY_W-1:0]  pay_ff, pay_in;
   logic [adq_pkg::STAT_W-1:0] res_stat_ff, res_stat_in;
   adq_pkg::entry_type         res_ent_ff, res_ent_in;

   logic                       out_valid_ff, out_valid_in;
   logic [adq_pkg::STAT_W-1:0] out_stat_ff, out_stat_in;
   adq_pkg::entry_type         out_ent_ff, out_ent_in;
   logic [adq_pkg::OCC_W-1:0]  out_occ_ff, out_occ_in;

   logic          accept, full, out_free, hit, last, shift_end;
   logic [CW-1:0] count;

   assign req_if.ready = (state_ff == adq_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign full         = !empty_ff && (tail_ff == LAST_SLOT);
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign hit          = (mem_rdata.id == key_ff);
   assign last         = (rptr_ff == tail_ff);
   assign shift_end    = (rptr_ff == '0);
   assign count        = empty_ff ? '0 : (CW'(tail_ff) - CW'(head_ff) + CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = adq_pkg::ST_DONE;
               unique case (req_if.op)
                  adq_pkg::OP_PUSH_FRONT: begin
                     if (!full && !empty_ff && head_ff == '0) state_in = adq_pkg::ST_SHIFT;
                  end
                  adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_REAR: begin
                     if (!empty_ff) state_in = adq_pkg::ST_POP;
                  end
                  adq_pkg::OP_FIND_ID: begin
                     if (!empty_ff) state_in = adq_pkg::ST_FIND;
                  end
                  default: state_in = adq_pkg::ST_DONE;
               endcase
            end
         end
         adq_pkg::ST_POP:   state_in = adq_pkg::ST_DONE;
         adq_pkg::ST_SHIFT: begin
            if (shift_end) state_in = adq_pkg::ST_WRNEW;
         end
         adq_pkg::ST_WRNEW: state_in = adq_pkg::ST_DONE;
         adq_pkg::ST_FIND: begin
            if (hit || last) state_in = adq_pkg::ST_DONE;
         end
         adq_pkg::ST_DONE: begin
            if (out_free) state_in = adq_pkg::ST_IDLE;
         end
         default: state_in = adq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      rptr_in      = rptr_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      res_stat_in  = res_stat_ff;
      res_ent_in   = res_ent_ff;
      out_stat_in  = out_stat_ff;
      out_ent_in   = out_ent_ff;
      out_occ_in   = out_occ_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '{id: req_if.customer_id, payload: req_if.entry_payload};
      mem_raddr    = rptr_ff;
      unique case (state_ff)
         adq_pkg::ST_IDLE: begin
            if (accept) begin
               key_in      = req_if.customer_id;
               pay_in      = req_if.entry_payload;
               res_stat_in = adq_pkg::STAT_OK;
               res_ent_in  = '0;
               unique case (req_if.op)
                  adq_pkg::OP_PUSH_FRONT, adq_pkg::OP_PUSH_REAR: begin
                     if (full) begin
                        res_stat_in = adq_pkg::STAT_FULL;
                     end else if (empty_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        empty_in = 1'b0;
                        mem_we   = 1'b1;
                     end else if (req_if.op == adq_pkg::OP_PUSH_REAR) begin
                        tail_in   = tail_ff + AW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = tail_ff + AW'(1);
                     end else if (head_ff == '0) begin
                        // front at slot 0: walk the entries up from the tail
                        tail_in   = tail_ff + AW'(1);
                        rptr_in   = tail_ff;
                        mem_raddr = tail_ff;
                     end else begin
                        head_in   = head_ff - AW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = head_ff - AW'(1);
                     end
                  end
                  adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_REAR: begin
                     if (empty_ff) begin
                        res_stat_in = adq_pkg::STAT_EMPTY;
                     end else begin
                        mem_raddr = (req_if.op == adq_pkg::OP_POP_FRONT) ? head_ff : tail_ff;
                        if (head_ff == tail_ff) begin
                           empty_in = 1'b1;
                           head_in  = '0;
                           tail_in  = '0;
                        end else if (req_if.op == adq_pkg::OP_POP_FRONT) begin
                           head_in = head_ff + AW'(1);
                        end else begin
                           tail_in = tail_ff - AW'(1);
                        end
                     end
                  end
                  adq_pkg::OP_FIND_ID: begin
                     if (empty_ff) begin
                        res_stat_in = adq_pkg::STAT_EMPTY;
                     end else begin
                        res_stat_in = adq_pkg::STAT_NOTFOUND;
                        rptr_in     = head_ff;
                        mem_raddr   = head_ff;
                     end
                  end
                  default: res_stat_in = adq_pkg::STAT_OK;
               endcase
            end
         end
         adq_pkg::ST_POP: begin
            res_ent_in = mem_rdata;
         end
         adq_pkg::ST_SHIFT: begin
            // data read last cycle from rptr moves up one slot
            mem_we    = 1'b1;
            mem_waddr = rptr_ff + AW'(1);
            mem_wdata = mem_rdata;
            if (!shift_end) begin
               rptr_in   = rptr_ff - AW'(1);
               mem_raddr = rptr_ff - AW'(1);
            end
         end
         adq_pkg::ST_WRNEW: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{id: key_ff, payload: pay_ff};
         end
         adq_pkg::ST_FIND: begin
            if (hit) begin
               res_stat_in = adq_pkg::STAT_OK;
               res_ent_in  = mem_rdata;
            end else if (!last) begin
               rptr_in   = rptr_ff + AW'(1);
               mem_raddr = rptr_ff + AW'(1);
            end
         end
         adq_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_stat_in  = res_stat_ff;
               out_ent_in   = res_ent_ff;
               out_occ_in   = adq_pkg::OCC_W'(count);
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff     <= rptr_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      res_stat_ff <= res_stat_in;
      res_ent_ff  <= res_ent_in;
      out_stat_ff <= out_stat_in;
      out_ent_ff  <= out_ent_in;
      out_occ_ff  <= out_occ_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.status      = out_stat_ff;
   assign rsp_if.out_id      = out_ent_ff.id;
   assign rsp_if.out_payload = out_ent_ff.payload;
   assign rsp_if.occupancy   = out_occ_ff;

endmodule

// ===== verif/array_deque_with_id_search_top_tb.sv =====
// Self-checking testbench for array_deque_with_id_search_top.
// Drives request transactions over adq_req_ifc, checks response transactions on adq_rsp_ifc
// against a cycle-free deque predictor. Depends on adq_pkg, adq_ifc and the design.
module array_deque_with_id_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = adq_pkg::DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 560;
   // Drain wait: worst front push shift or find walks the whole array.
   localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;
   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 5000;

   // Op codes the block treats as no-ops (OK status, deque unchanged).
   localparam logic [adq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [adq_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [adq_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   // Idle modes, cycled through as request transactions are accepted.
   localparam int MODE_NONE     = 0;
   localparam int MODE_SENDER   = 1;
   localparam int MODE_RECEIVER = 2;
   localparam int MODE_BOTH     = 3;

   typedef struct {
      logic [adq_pkg::OP_W-1:0]        op;
      logic signed [adq_pkg::ID_W-1:0] id;
      logic [adq_pkg::PAY_W-1:0]       payload;
   } deque_req_type;

   typedef struct {
      logic [adq_pkg::STAT_W-1:0]      status;
      logic signed [adq_pkg::ID_W-1:0] out_id;
      logic [adq_pkg::PAY_W-1:0]       out_payload;
      logic [adq_pkg::OCC_W-1:0]       occupancy;
   } deque_rsp_type;

   logic clock;
   logic reset;

   adq_req_ifc req_if ();
   adq_rsp_ifc rsp_if ();

   array_deque_with_id_search_top #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // Pending request transactions, and the responses they should produce.
   deque_req_type pending_reqs[$];
   deque_rsp_type expected_rsps[$];
   deque_req_type offered_req;

   int accepted_count = 0;
   int total_items    = 1;
   int error_count    = 0;

   // Predictor state: entries occupy dq_store[dq_head..dq_tail].
   adq_pkg::entry_type dq_store[DEPTH];
   int                 dq_head  = 0;
   int                 dq_tail  = 0;
   bit                 dq_empty = 1'b1;

   // Apply one request to the predicted deque and return its response.
   function automatic deque_rsp_type deque_predict(deque_req_type rq);
      deque_rsp_type r;
      int            idx;
      int            slot;
      bit            found;
      r.status      = adq_pkg::STAT_OK;
      r.out_id      = '0;
      r.out_payload = '0;
      found         = 1'b0;
      case (rq.op)
         adq_pkg::OP_PUSH_FRONT, adq_pkg::OP_PUSH_REAR: begin
            // full is tail at the last slot, even with free slots below head
            if (!dq_empty && dq_tail == DEPTH - 1) begin
               r.status = adq_pkg::STAT_FULL;
            end else if (dq_empty) begin
               dq_head     = 0;
               dq_tail     = 0;
               dq_empty    = 1'b0;
               dq_store[0] = {rq.id, rq.payload};
            end else if (rq.op == adq_pkg::OP_PUSH_REAR) begin
               dq_tail++;
               dq_store[dq_tail] = {rq.id, rq.payload};
            end else if (dq_head == 0) begin
               // front at slot 0: shift every entry up one
               for (idx = dq_tail + 1; idx > 0; idx--) begin
                  dq_store[idx] = dq_store[idx-1];
               end
               dq_tail++;
               dq_store[0] = {rq.id, rq.payload};
            end else begin
               dq_head--;
               dq_store[dq_head] = {rq.id, rq.payload};
            end
         end
         adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_REAR: begin
            if (dq_empty) begin
               r.status = adq_pkg::STAT_EMPTY;
            end else begin
               slot          = (rq.op == adq_pkg::OP_POP_FRONT) ? dq_head : dq_tail;
               r.out_id      = dq_store[slot].id;
               r.out_payload = dq_store[slot].payload;
               if (dq_head == dq_tail) begin
                  dq_empty = 1'b1;
                  dq_head  = 0;
                  dq_tail  = 0;
               end else if (rq.op == adq_pkg::OP_POP_FRONT) begin
                  dq_head++;
               end else begin
                  dq_tail--;
               end
            end
         end
         adq_pkg::OP_FIND_ID: begin
            if (dq_empty) begin
               r.status = adq_pkg::STAT_EMPTY;
            end else begin
               r.status = adq_pkg::STAT_NOTFOUND;
               for (idx = dq_head; idx <= dq_tail && !found; idx++) begin
                  if (dq_store[idx].id == rq.id) begin
                     found         = 1'b1;
                     r.status      = adq_pkg::STAT_OK;
                     r.out_id      = dq_store[idx].id;
                     r.out_payload = dq_store[idx].payload;
                  end
               end
            end
         end
         default: ;
      endcase
      r.occupancy = dq_empty ? '0 : adq_pkg::OCC_W'(dq_tail - dq_head + 1);
      return r;
   endfunction

   task automatic queue_req(logic [adq_pkg::OP_W-1:0] op,
                            logic signed [adq_pkg::ID_W-1:0] id,
                            logic [adq_pkg::PAY_W-1:0] payload);
      deque_req_type rq;
      rq.op      = op;
      rq.id      = id;
      rq.payload = payload;
      pending_reqs.push_back(rq);
   endtask

   // Ids from a small pool 45 percent of the time, else random, so finds hit and duplicates appear.
   function automatic logic signed [adq_pkg::ID_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= 45) return $urandom;
      case ($urandom_range(0, 7))
         0: return -1;
         1: return 0;
         2: return 1;
         3: return 2;
         4: return 3;
         5: return 32'sh8000_0000;
         6: return 32'sh7fff_ffff;
         default: return 32'sh1234_5678;
      endcase
   endfunction

   // Idle mode follows the share of transactions accepted so far.
   function automatic int idle_mode();
      return ((accepted_count * 8) / total_items) % 4;
   endfunction

   // Driver: offers the next pending request; predicts when one is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(deque_predict(offered_req));
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() > 0 &&
                !((idle_mode() == MODE_SENDER && $urandom_range(0, 99) < 81) ||
                  (idle_mode() == MODE_BOTH && $urandom_range(0, 99) < 34))) begin
               offered_req           = pending_reqs.pop_front();
               req_if.valid         <= 1'b1;
               req_if.op            <= offered_req.op;
               req_if.customer_id   <= offered_req.id;
               req_if.entry_payload <= offered_req.payload;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random backpressure, compares each response with the oldest prediction.
   always @(posedge clock) begin
      deque_rsp_type exp_rsp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !((idle_mode() == MODE_RECEIVER && $urandom_range(0, 99) < 81) ||
                           (idle_mode() == MODE_BOTH && $urandom_range(0, 99) < 34));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t unexpected response: status %0d id %0d payload %h occ %0d",
                           $realtime, rsp_if.status, rsp_if.out_id, rsp_if.out_payload,
                           rsp_if.occupancy);
               end
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_if.status !== exp_rsp.status || rsp_if.out_id !== exp_rsp.out_id ||
                   rsp_if.out_payload !== exp_rsp.out_payload ||
                   rsp_if.occupancy !== exp_rsp.occupancy) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t mismatch: expected status %0d id %0d payload %h occ %0d",
                              $realtime, exp_rsp.status, exp_rsp.out_id,
                              exp_rsp.out_payload, exp_rsp.occupancy);
                     $display("%0t          actual   status %0d id %0d payload %h occ %0d",
                              $realtime, rsp_if.status, rsp_if.out_id,
                              rsp_if.out_payload, rsp_if.occupancy);
                  end
               end
            end
         end
      end
   end

   // Watchdog: any cycle with an accepted transaction on either side resets the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("array_deque_with_id_search_top_tb: errors");
      $finish;
   end

   // Stimulus build, reset, and end of run.
   initial begin
      int  roll;
      int  run_len;
      int  made;
      int  step;
      bit  fill_run;

      clock                = 1'b0;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.op            = adq_pkg::OP_PUSH_FRONT;
      req_if.customer_id   = '0;
      req_if.entry_payload = '0;
      rsp_if.ready         = 1'b0;

      // Directed: empty-queue answers, ignored codes, id extremes, both shift and
      // no-shift front pushes, hit/miss/duplicate finds, draining to empty.
      queue_req(adq_pkg::OP_POP_FRONT,  0, 32'h0);
      queue_req(adq_pkg::OP_POP_REAR,   0, 32'h0);
      queue_req(adq_pkg::OP_FIND_ID,    -1, 32'h0);
      queue_req(OP_SPARE_FIRST,         32'sh7fff_ffff, 32'hffff_ffff);
      queue_req(OP_SPARE_MID,           -1, 32'h0);
      queue_req(OP_SPARE_LAST,          32'sh8000_0000, 32'h1234_5678);
      queue_req(adq_pkg::OP_PUSH_REAR,  32'sh8000_0000, 32'h0000_0000);
      queue_req(adq_pkg::OP_PUSH_REAR,  32'sh7fff_ffff, 32'hffff_ffff);
      queue_req(adq_pkg::OP_PUSH_FRONT, 0, 32'ha5a5_a5a5);
      queue_req(adq_pkg::OP_PUSH_FRONT, -1, 32'h5a5a_5a5a);
      queue_req(adq_pkg::OP_FIND_ID,    -1, 32'h0);
      queue_req(adq_pkg::OP_FIND_ID,    12345, 32'h0);
      queue_req(adq_pkg::OP_FIND_ID,    32'sh7fff_ffff, 32'h0);
      queue_req(adq_pkg::OP_POP_FRONT,  0, 32'h0);
      // head is now off slot 0, so this front push needs no shift
      queue_req(adq_pkg::OP_PUSH_FRONT, 7, 32'h0bad_f00d);
      queue_req(adq_pkg::OP_POP_REAR,   0, 32'h0);
      queue_req(OP_SPARE_LAST,          3, 32'hdead_beef);
      queue_req(adq_pkg::OP_POP_REAR,   0, 32'h0);
      queue_req(adq_pkg::OP_POP_FRONT,  0, 32'h0);
      queue_req(adq_pkg::OP_POP_FRONT,  0, 32'h0);
      queue_req(adq_pkg::OP_POP_FRONT,  0, 32'h0);
      queue_req(adq_pkg::OP_PUSH_REAR,  3, 32'h1111_1111);
      queue_req(adq_pkg::OP_PUSH_REAR,  3, 32'h2222_2222);
      queue_req(adq_pkg::OP_FIND_ID,    3, 32'h0);

      // Random: alternating fill runs (reach full, front shifts) and drain runs
      // (reach empty). Ignored codes do not count toward RANDOM_ITEMS.
      made     = 0;
      fill_run = 1'b1;
      while (made < RANDOM_ITEMS) begin
         run_len = $urandom_range(60, 120);
         for (step = 0; step < run_len && made < RANDOM_ITEMS; step++) begin
            roll = $urandom_range(0, 99);
            if (roll >= 97) begin
               queue_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom, $urandom);
            end else begin
               made++;
               if (roll >= 87) begin
                  queue_req(adq_pkg::OP_FIND_ID, pick_id(), $urandom);
               end else if (fill_run ? (roll < 80) : (roll >= 80)) begin
                  queue_req(($urandom_range(0, 1) != 0) ? adq_pkg::OP_PUSH_FRONT :
                                                          adq_pkg::OP_PUSH_REAR,
                            pick_id(), $urandom);
               end else begin
                  queue_req(($urandom_range(0, 1) != 0) ? adq_pkg::OP_POP_FRONT :
                                                          adq_pkg::OP_POP_REAR,
                            $urandom, $urandom);
               end
            end
         end
         fill_run = !fill_run;
      end
      total_items = pending_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so driver and monitor updates have settled.
      while (accepted_count < total_items || expected_rsps.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("array_deque_with_id_search_top_tb: clean");
      end else begin
         $display("array_deque_with_id_search_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== array_deque_with_id_search_top.f =====
design/adq_pkg.sv
design/adq_ifc.sv
design/adq_mem.sv
design/adq_ctrl.sv
design/array_deque_with_id_search_top.sv
verif/array_deque_with_id_search_top_tb.sv
